/* rtl/core/spfj_pkg.sv */
package spfj_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 31;
   localparam int DIFF_W    = VAL_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int ROOT_W    = DIFF_W;
   localparam int QUO_W     = CFG_W + FRAC_BITS;
   localparam int UNIT_W    = FRAC_BITS + 1;
   localparam int UNUM_W    = DIFF_W + FRAC_BITS;
   localparam int WIDE_W    = 64;
   localparam int MUL_LAT   = 4;

   localparam logic signed [WIDE_W-1:0] LIM = 64'sh1FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] ONE = 64'sd1 <<< FRAC_BITS;

   typedef enum logic [1:0] {
      CSR_MASS         = 2'd0,
      CSR_STIFFNESS    = 2'd1,
      CSR_REST_LENGTH  = 2'd2,
      CSR_MIN_DISTANCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] pos_i_x;
      logic signed [VAL_W-1:0] pos_i_y;
      logic signed [VAL_W-1:0] pos_j_x;
      logic signed [VAL_W-1:0] pos_j_y;
      logic signed [VAL_W-1:0] adj_vel_x;
      logic signed [VAL_W-1:0] adj_vel_y;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] accel_x;
      logic signed [VAL_W-1:0] accel_y;
      logic signed [VAL_W-1:0] grad_i_x;
      logic signed [VAL_W-1:0] grad_i_y;
      logic signed [VAL_W-1:0] grad_j_x;
      logic signed [VAL_W-1:0] grad_j_y;
      logic                    too_close;
   } rsp_type;

   // saturate to the internal +-LIM range
   function automatic logic signed [WIDE_W-1:0] clamp_lim(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      r = v;
      if (v > LIM) r = LIM;
      if (v < -LIM) r = -LIM;
      return r;
   endfunction

   // saturate to a 32-bit output value
   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      r = VAL_W'(v);
      if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      return r;
   endfunction

endpackage

/* rtl/core/spfj_delay.sv */
module spfj_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] stage_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q = stage_ff[N-1];

endmodule

/* rtl/core/spfj_isqrt.sv */
module spfj_isqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [spfj_pkg::SQ_W-1:0]      val,
   output logic [spfj_pkg::ROOT_W-1:0]    root
);

   localparam int NS = spfj_pkg::ROOT_W;
   localparam int VW = spfj_pkg::SQ_W;
   localparam int RW = NS + 3;

   logic [RW-1:0] rem_ff  [NS];
   logic [NS-1:0] root_ff [NS];
   logic [VW-1:0] val_ff  [NS];

   logic [RW-1:0] rem_in  [NS];
   logic [NS-1:0] root_in [NS];
   logic [VW-1:0] val_in  [NS];

   // one result bit per stage, most significant pair first
   always_comb begin
      logic [RW-1:0] rem_prev;
      logic [NS-1:0] root_prev;
      logic [VW-1:0] val_prev;
      logic [RW-1:0] r2;
      logic [RW-1:0] trial;
      for (int i = 0; i < NS; i++) begin
         if (i == 0) begin
            rem_prev  = '0;
            root_prev = '0;
            val_prev  = val;
         end else begin
            rem_prev  = rem_ff[i-1];
            root_prev = root_ff[i-1];
            val_prev  = val_ff[i-1];
         end
         r2    = {rem_prev[RW-3:0], val_prev[2*(NS-1-i) +: 2]};
         trial = RW'({root_prev, 2'b01});
         if (r2 >= trial) begin
            rem_in[i]  = r2 - trial;
            root_in[i] = {root_prev[NS-2:0], 1'b1};
         end else begin
            rem_in[i]  = r2;
            root_in[i] = {root_prev[NS-2:0], 1'b0};
         end
         val_in[i] = val_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NS; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            val_ff[i]  <= val_in[i];
         end
      end
   end

   assign root = root_ff[NS-1];

endmodule

/* rtl/core/spfj_div.sv */
module spfj_div #(
   parameter int NW = 47,
   parameter int DW = 33,
   parameter int QW = 47
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   // restoring divide, one quotient bit per stage; num >> QW must be below den
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];

   logic [DW-1:0] rem_in [QW];
   logic [QW-1:0] low_in [QW];
   logic [DW-1:0] den_in [QW];

   always_comb begin
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [DW-1:0] den_prev;
      logic [DW:0]   r2;
      logic          ge;
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            rem_prev = DW'(num >> QW);
            low_prev = num[QW-1:0];
            den_prev = den;
         end else begin
            rem_prev = rem_ff[i-1];
            low_prev = low_ff[i-1];
            den_prev = den_ff[i-1];
         end
         r2 = {rem_prev, low_prev[QW-1]};
         ge = (r2 >= {1'b0, den_prev});
         if (ge) r2 = r2 - {1'b0, den_prev};
         rem_in[i] = r2[DW-1:0];
         low_in[i] = {low_prev[QW-2:0], ge};
         den_in[i] = den_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
            den_ff[i] <= den_in[i];
         end
      end
   end

   assign quo = low_ff[QW-1];

endmodule

/* rtl/core/spfj_mul.sv */
module spfj_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [spfj_pkg::WIDE_W-1:0]  a,
   input  logic signed [spfj_pkg::WIDE_W-1:0]  b,
   output logic signed [spfj_pkg::WIDE_W-1:0]  p
);

   // Q-format product, round half away from zero, saturate to +-LIM.
   // Operand magnitudes stay below 2^62; split into 31-bit halves.
   localparam int HW = 31;
   localparam int MW = 2 * HW;
   localparam int FW = 2 * MW;
   localparam logic [FW-1:0] RND = FW'(1) << (spfj_pkg::FRAC_BITS - 1);

   logic          neg1_ff, neg2_ff, neg3_ff;
   logic [MW-1:0] am1_ff, bm1_ff;
   logic [MW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [FW-1:0] full3_ff;
   logic signed [spfj_pkg::WIDE_W-1:0] p_ff;

   logic [spfj_pkg::WIDE_W-1:0] am_in, bm_in;
   logic [FW-1:0] full_in;
   logic [FW-1:0] shr;
   logic [spfj_pkg::WIDE_W-1:0] mag_in;

   always_comb begin
      am_in   = a[spfj_pkg::WIDE_W-1] ? spfj_pkg::WIDE_W'(-a) : a;
      bm_in   = b[spfj_pkg::WIDE_W-1] ? spfj_pkg::WIDE_W'(-b) : b;
      full_in = {p11_ff, {MW{1'b0}}}
              + (FW'(p01_ff) << HW) + (FW'(p10_ff) << HW)
              + FW'(p00_ff) + RND;
      shr     = full3_ff >> spfj_pkg::FRAC_BITS;
      if (shr > FW'(spfj_pkg::LIM)) mag_in = spfj_pkg::LIM;
      else mag_in = shr[spfj_pkg::WIDE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= a[spfj_pkg::WIDE_W-1] ^ b[spfj_pkg::WIDE_W-1];
         am1_ff   <= am_in[MW-1:0];
         bm1_ff   <= bm_in[MW-1:0];
         neg2_ff  <= neg1_ff;
         p00_ff   <= am1_ff[HW-1:0] * bm1_ff[HW-1:0];
         p01_ff   <= am1_ff[HW-1:0] * bm1_ff[MW-1:HW];
         p10_ff   <= am1_ff[MW-1:HW] * bm1_ff[HW-1:0];
         p11_ff   <= am1_ff[MW-1:HW] * bm1_ff[MW-1:HW];
         neg3_ff  <= neg2_ff;
         full3_ff <= full_in;
         p_ff     <= neg3_ff ? -$signed(mag_in) : $signed(mag_in);
      end
   end

   assign p = p_ff;

endmodule

/* rtl/core/spring_pair_force_jacobian_unit.sv */
// Spring pair force and Jacobian unit. Takes the positions of two masses and an
// adjoint velocity vector per transfer and returns the spring acceleration on
// mass i, (k/m)(1-L/d)(dx,dy), plus the transposed-Jacobian products for both
// masses, all signed Q16.16 with saturation. When the distance d falls below
// min_distance (or is zero) every value is zero and too_close is set. The unit is
// a fully pipelined datapath: one transfer can enter every cycle while no
// finished result is stalled, and each result passes through the 33-stage
// square root pipeline followed by the 47-stage restoring divider for L/d and
// k/m, then four levels of 4-stage multipliers with two add/clamp stages. A
// stalled result holds the whole pipeline in place; nothing is dropped. The
// configuration registers may only be written while no transfer is in flight.
module spring_pair_force_jacobian_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  spfj_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output spfj_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [spfj_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int DW_ = spfj_pkg::DIFF_W;
   localparam int WW  = spfj_pkg::WIDE_W;
   localparam int ML  = spfj_pkg::MUL_LAT;

   // stage numbers: a value registered at stage s lies s registers behind the request
   localparam int S_SQ   = 3;
   localparam int S_ROOT = S_SQ + spfj_pkg::ROOT_W;
   localparam int S_CHK  = S_ROOT + 1;
   localparam int S_DIV  = S_CHK + spfj_pkg::QUO_W;
   localparam int S_L1   = S_DIV + ML;
   localparam int S_L2   = S_L1 + ML;
   localparam int S_J    = S_L2 + 1;
   localparam int S_L3   = S_J + ML;
   localparam int S_S    = S_L3 + 1;
   localparam int S_L5   = S_S + ML;

   // ---------------- configuration registers ----------------
   logic [spfj_pkg::CFG_W-1:0] mass_ff, stiff_ff, rest_ff, mind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff  <= 31'd65536;
         stiff_ff <= 31'd65536;
         rest_ff  <= 31'd65536;
         mind_ff  <= 31'd13107;
      end else if (csr_we) begin
         case (spfj_pkg::csr_index_type'(csr_index))
            spfj_pkg::CSR_MASS:         mass_ff  <= csr_wdata;
            spfj_pkg::CSR_STIFFNESS:    stiff_ff <= csr_wdata;
            spfj_pkg::CSR_REST_LENGTH:  rest_ff  <= csr_wdata;
            spfj_pkg::CSR_MIN_DISTANCE: mind_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // advance the whole pipeline unless a finished result is waiting
   logic en;
   logic rsp_valid_ff;
   logic [S_L5-1:0] vld_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[S_L5-2:0], req_valid};
         rsp_valid_ff <= vld_ff[S_L5-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- differences and squares ----------------
   logic signed [DW_-1:0] dx1_ff, dy1_ff;
   logic signed [spfj_pkg::VAL_W-1:0] vx1_ff, vy1_ff;
   logic [DW_-1:0] magx, magy;
   logic [spfj_pkg::SQ_W-1:0] sqx2_ff, sqy2_ff, sum3_ff;

   assign magx = dx1_ff[DW_-1] ? DW_'(-dx1_ff) : dx1_ff;
   assign magy = dy1_ff[DW_-1] ? DW_'(-dy1_ff) : dy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff  <= DW_'(req_data.pos_j_x) - DW_'(req_data.pos_i_x);
         dy1_ff  <= DW_'(req_data.pos_j_y) - DW_'(req_data.pos_i_y);
         vx1_ff  <= req_data.adj_vel_x;
         vy1_ff  <= req_data.adj_vel_y;
         sqx2_ff <= spfj_pkg::SQ_W'(magx) * spfj_pkg::SQ_W'(magx);
         sqy2_ff <= spfj_pkg::SQ_W'(magy) * spfj_pkg::SQ_W'(magy);
         sum3_ff <= sqx2_ff + sqy2_ff;
      end
   end

   // ---------------- distance ----------------
   logic [spfj_pkg::ROOT_W-1:0] root;
   logic [spfj_pkg::ROOT_W-1:0] dsafe_ff;
   logic                        tc_ff;

   spfj_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .val   (sum3_ff),
      .root  (root)
   );

   // flag the too-close case and keep the divisor nonzero
   always_ff @(posedge clock) begin
      if (en) begin
         tc_ff    <= (root == '0) || (root < spfj_pkg::ROOT_W'(mind_ff));
         dsafe_ff <= (root == '0) ? spfj_pkg::ROOT_W'(1) : root;
      end
   end

   // carry the differences and the adjoint vector alongside
   logic [2*DW_-1:0] dxy_c, dxy_d;
   logic [2*spfj_pkg::VAL_W-1:0] vxy_j;
   logic tc_o;

   spfj_delay #(.W(2*DW_), .N(S_CHK-1)) u_dly_dxy_c (
      .clock(clock), .en(en), .d({dx1_ff, dy1_ff}), .q(dxy_c));
   spfj_delay #(.W(2*DW_), .N(S_DIV-S_CHK)) u_dly_dxy_d (
      .clock(clock), .en(en), .d(dxy_c), .q(dxy_d));
   spfj_delay #(.W(2*spfj_pkg::VAL_W), .N(S_J-1)) u_dly_v (
      .clock(clock), .en(en), .d({vx1_ff, vy1_ff}), .q(vxy_j));
   spfj_delay #(.W(1), .N(S_L5-S_CHK)) u_dly_tc (
      .clock(clock), .en(en), .d(tc_ff), .q(tc_o));

   // ---------------- divisions ----------------
   logic signed [DW_-1:0] dx_c, dy_c;
   logic [DW_-1:0] magx_c, magy_c;
   logic [spfj_pkg::CFG_W-1:0] mass_safe;
   logic [spfj_pkg::QUO_W-1:0] q_quo, g_quo;
   logic [spfj_pkg::UNIT_W-1:0] ux_quo, uy_quo;
   logic [2*spfj_pkg::UNIT_W-1:0] uxy_d;

   assign dx_c      = dxy_c[2*DW_-1:DW_];
   assign dy_c      = dxy_c[DW_-1:0];
   assign magx_c    = dx_c[DW_-1] ? DW_'(-dx_c) : dx_c;
   assign magy_c    = dy_c[DW_-1] ? DW_'(-dy_c) : dy_c;
   assign mass_safe = (mass_ff == '0) ? spfj_pkg::CFG_W'(1) : mass_ff;

   spfj_div #(.NW(spfj_pkg::QUO_W), .DW(spfj_pkg::ROOT_W), .QW(spfj_pkg::QUO_W)) u_div_q (
      .clock(clock), .en(en),
      .num({rest_ff, {spfj_pkg::FRAC_BITS{1'b0}}}), .den(dsafe_ff), .quo(q_quo));
   spfj_div #(.NW(spfj_pkg::QUO_W), .DW(spfj_pkg::CFG_W), .QW(spfj_pkg::QUO_W)) u_div_g (
      .clock(clock), .en(en),
      .num({stiff_ff, {spfj_pkg::FRAC_BITS{1'b0}}}), .den(mass_safe), .quo(g_quo));
   spfj_div #(.NW(spfj_pkg::UNUM_W), .DW(spfj_pkg::ROOT_W), .QW(spfj_pkg::UNIT_W)) u_div_ux (
      .clock(clock), .en(en),
      .num({magx_c, {spfj_pkg::FRAC_BITS{1'b0}}}), .den(dsafe_ff), .quo(ux_quo));
   spfj_div #(.NW(spfj_pkg::UNUM_W), .DW(spfj_pkg::ROOT_W), .QW(spfj_pkg::UNIT_W)) u_div_uy (
      .clock(clock), .en(en),
      .num({magy_c, {spfj_pkg::FRAC_BITS{1'b0}}}), .den(dsafe_ff), .quo(uy_quo));

   spfj_delay #(.W(2*spfj_pkg::UNIT_W), .N(spfj_pkg::QUO_W-spfj_pkg::UNIT_W)) u_dly_u (
      .clock(clock), .en(en), .d({ux_quo, uy_quo}), .q(uxy_d));

   // ---------------- level 1: unit products and w*d ----------------
   logic signed [DW_-1:0] dx_d, dy_d;
   logic signed [WW-1:0] ux_s, uy_s, q64, w64, dx64, dy64;
   logic signed [WW-1:0] uxux, uxuy, uyuy, wdx, wdy;

   assign dx_d = dxy_d[2*DW_-1:DW_];
   assign dy_d = dxy_d[DW_-1:0];
   assign ux_s = dx_d[DW_-1] ? -WW'(uxy_d[2*spfj_pkg::UNIT_W-1:spfj_pkg::UNIT_W])
                             :  WW'(uxy_d[2*spfj_pkg::UNIT_W-1:spfj_pkg::UNIT_W]);
   assign uy_s = dy_d[DW_-1] ? -WW'(uxy_d[spfj_pkg::UNIT_W-1:0])
                             :  WW'(uxy_d[spfj_pkg::UNIT_W-1:0]);
   assign q64  = WW'(q_quo);
   assign w64  = spfj_pkg::ONE - q64;
   assign dx64 = WW'(dx_d);
   assign dy64 = WW'(dy_d);

   spfj_mul u_m_uxux (.clock(clock), .en(en), .a(ux_s), .b(ux_s), .p(uxux));
   spfj_mul u_m_uxuy (.clock(clock), .en(en), .a(ux_s), .b(uy_s), .p(uxuy));
   spfj_mul u_m_uyuy (.clock(clock), .en(en), .a(uy_s), .b(uy_s), .p(uyuy));
   spfj_mul u_m_wdx  (.clock(clock), .en(en), .a(w64),  .b(dx64), .p(wdx));
   spfj_mul u_m_wdy  (.clock(clock), .en(en), .a(w64),  .b(dy64), .p(wdy));

   // ---------------- level 2: L/d^3 terms and acceleration ----------------
   logic [spfj_pkg::QUO_W-1:0] q_l1, q_l2, g_l1, g_s;
   logic signed [WW-1:0] q_l1s, g_l1s, w_l2, g_ss;
   logic signed [WW-1:0] pxx, pxy, pyy, acc_x, acc_y;
   logic [2*spfj_pkg::VAL_W-1:0] acc_o;

   spfj_delay #(.W(spfj_pkg::QUO_W), .N(ML)) u_dly_q1 (
      .clock(clock), .en(en), .d(q_quo), .q(q_l1));
   spfj_delay #(.W(spfj_pkg::QUO_W), .N(ML)) u_dly_q2 (
      .clock(clock), .en(en), .d(q_l1), .q(q_l2));
   spfj_delay #(.W(spfj_pkg::QUO_W), .N(ML)) u_dly_g1 (
      .clock(clock), .en(en), .d(g_quo), .q(g_l1));
   spfj_delay #(.W(spfj_pkg::QUO_W), .N(S_S-S_L1)) u_dly_g5 (
      .clock(clock), .en(en), .d(g_l1), .q(g_s));

   assign q_l1s = WW'(q_l1);
   assign g_l1s = WW'(g_l1);
   assign w_l2  = spfj_pkg::ONE - WW'(q_l2);
   assign g_ss  = WW'(g_s);

   spfj_mul u_m_pxx (.clock(clock), .en(en), .a(q_l1s), .b(uxux), .p(pxx));
   spfj_mul u_m_pxy (.clock(clock), .en(en), .a(q_l1s), .b(uxuy), .p(pxy));
   spfj_mul u_m_pyy (.clock(clock), .en(en), .a(q_l1s), .b(uyuy), .p(pyy));
   spfj_mul u_m_ax  (.clock(clock), .en(en), .a(g_l1s), .b(wdx),  .p(acc_x));
   spfj_mul u_m_ay  (.clock(clock), .en(en), .a(g_l1s), .b(wdy),  .p(acc_y));

   spfj_delay #(.W(2*spfj_pkg::VAL_W), .N(S_L5-S_L2)) u_dly_acc (
      .clock(clock), .en(en),
      .d({spfj_pkg::sat32(acc_x), spfj_pkg::sat32(acc_y)}), .q(acc_o));

   // ---------------- Jacobian entries ----------------
   logic signed [WW-1:0] jxx_ff, jxy_ff, jyy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         jxx_ff <= spfj_pkg::clamp_lim(-w_l2 - pxx);
         jxy_ff <= -pxy;
         jyy_ff <= spfj_pkg::clamp_lim(-w_l2 - pyy);
      end
   end

   // ---------------- level 3: J^T v ----------------
   logic signed [WW-1:0] vx64, vy64;
   logic signed [WW-1:0] t_xx, t_xy, t_yx, t_yy;
   logic signed [WW-1:0] sx_ff, sy_ff;

   assign vx64 = WW'($signed(vxy_j[2*spfj_pkg::VAL_W-1:spfj_pkg::VAL_W]));
   assign vy64 = WW'($signed(vxy_j[spfj_pkg::VAL_W-1:0]));

   spfj_mul u_m_txx (.clock(clock), .en(en), .a(jxx_ff), .b(vx64), .p(t_xx));
   spfj_mul u_m_txy (.clock(clock), .en(en), .a(jxy_ff), .b(vy64), .p(t_xy));
   spfj_mul u_m_tyx (.clock(clock), .en(en), .a(jxy_ff), .b(vx64), .p(t_yx));
   spfj_mul u_m_tyy (.clock(clock), .en(en), .a(jyy_ff), .b(vy64), .p(t_yy));

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff <= spfj_pkg::clamp_lim(t_xx + t_xy);
         sy_ff <= spfj_pkg::clamp_lim(t_yx + t_yy);
      end
   end

   // ---------------- level 5: scale by k/m ----------------
   logic signed [WW-1:0] gx, gy;

   spfj_mul u_m_gx (.clock(clock), .en(en), .a(g_ss), .b(sx_ff), .p(gx));
   spfj_mul u_m_gy (.clock(clock), .en(en), .a(g_ss), .b(sy_ff), .p(gy));

   // ---------------- output register ----------------
   spfj_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.too_close = tc_o;
      if (tc_o) begin
         rsp_in.accel_x  = '0;
         rsp_in.accel_y  = '0;
         rsp_in.grad_i_x = '0;
         rsp_in.grad_i_y = '0;
         rsp_in.grad_j_x = '0;
         rsp_in.grad_j_y = '0;
      end else begin
         rsp_in.accel_x  = acc_o[2*spfj_pkg::VAL_W-1:spfj_pkg::VAL_W];
         rsp_in.accel_y  = acc_o[spfj_pkg::VAL_W-1:0];
         rsp_in.grad_i_x = spfj_pkg::sat32(gx);
         rsp_in.grad_i_y = spfj_pkg::sat32(gy);
         rsp_in.grad_j_x = spfj_pkg::sat32(-gx);
         rsp_in.grad_j_y = spfj_pkg::sat32(-gy);
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // ---------------- assertions ----------------
   // a too-close result carries only zero values
   a_tc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_close |->
         rsp_data.accel_x == 0 && rsp_data.accel_y == 0 &&
         rsp_data.grad_i_x == 0 && rsp_data.grad_i_y == 0 &&
         rsp_data.grad_j_x == 0 && rsp_data.grad_j_y == 0)
      else $error("too_close result with nonzero values");

   // away from saturation the mass j products mirror mass i
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.grad_i_x != 32'sh7FFF_FFFF &&
         rsp_data.grad_i_x != 32'sh8000_0000 |->
         rsp_data.grad_j_x == -rsp_data.grad_i_x)
      else $error("grad_j_x does not mirror grad_i_x");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import spfj_pkg::*;

   // Scoreboard: holds its own copy of the spring registers, predicts the
   // force/Jacobian result for each request and checks results in order.
   class spring_scoreboard;
      logic [CFG_W-1:0] mass_q, stiff_q, rest_q, min_q;
      rsp_type          expected_q[$];
      int               errors;
      int               checked;
      int               close_count;

      function new();
         mass_q  = 31'd65536;
         stiff_q = 31'd65536;
         rest_q  = 31'd65536;
         min_q   = 31'd13107;
      endfunction

      function void set_reg(csr_index_type idx, logic [CFG_W-1:0] v);
         case (idx)
            CSR_MASS:         mass_q  = v;
            CSR_STIFFNESS:    stiff_q = v;
            CSR_REST_LENGTH:  rest_q  = v;
            CSR_MIN_DISTANCE: min_q   = v;
            default: ;
         endcase
      endfunction

      function bit [63:0] mag(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      // rounded fixed-point product, ties away from zero, clamped to +-LIM
      function longint mulq(longint a, longint b);
         bit [127:0] p;
         longint     r;
         p = {64'd0, mag(a)} * {64'd0, mag(b)};
         p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         r = (p > 128'(LIM)) ? LIM : longint'(p[63:0]);
         return ((a < 0) != (b < 0)) ? -r : r;
      endfunction

      // fixed-point quotient truncated toward zero
      function longint divq(longint n, bit [63:0] dv);
         bit [63:0] r;
         r = (mag(n) << FRAC_BITS) / dv;
         return (n < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint clampi(longint v);
         return (v > LIM) ? LIM : ((v < -LIM) ? -LIM : v);
      endfunction

      function logic signed [31:0] sat_out(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      // digit-by-digit floor square root
      function bit [63:0] floor_root(bit [65:0] v);
         bit [69:0] rem, trial;
         bit [63:0] root;
         rem  = '0;
         root = '0;
         for (int k = 32; k >= 0; k--) begin
            rem   = (rem << 2) | 70'(v[2*k +: 2]);
            trial = 70'({root, 2'b01});
            if (rem >= trial) begin
               rem  = rem - trial;
               root = (root << 1) | 64'd1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      function rsp_type spring_force(req_type r);
         longint    dx, dy, vx, vy, g, q, w, ux, uy, pxx, pxy, pyy;
         longint    jxx, jxy, jyy, sx, sy, gx, gy;
         bit [65:0] sq;
         bit [63:0] d;
         rsp_type   e;
         dx = longint'(r.pos_j_x) - longint'(r.pos_i_x);
         dy = longint'(r.pos_j_y) - longint'(r.pos_i_y);
         vx = longint'(r.adj_vel_x);
         vy = longint'(r.adj_vel_y);
         sq = 66'(mag(dx)) * 66'(mag(dx)) + 66'(mag(dy)) * 66'(mag(dy));
         d  = floor_root(sq);
         e  = '0;
         if (d == 0 || d < 64'(min_q)) begin
            e.too_close = 1'b1;
            return e;
         end
         g   = divq(longint'(stiff_q), (mass_q == 0) ? 64'd1 : 64'(mass_q));
         q   = divq(longint'(rest_q), d);
         w   = ONE - q;
         ux  = divq(dx, d);
         uy  = divq(dy, d);
         pxx = mulq(q, mulq(ux, ux));
         pxy = mulq(q, mulq(ux, uy));
         pyy = mulq(q, mulq(uy, uy));
         jxx = clampi(-w - pxx);
         jxy = -pxy;
         jyy = clampi(-w - pyy);
         sx  = clampi(mulq(jxx, vx) + mulq(jxy, vy));
         sy  = clampi(mulq(jxy, vx) + mulq(jyy, vy));
         gx  = mulq(g, sx);
         gy  = mulq(g, sy);
         e.accel_x  = sat_out(mulq(g, mulq(w, dx)));
         e.accel_y  = sat_out(mulq(g, mulq(w, dy)));
         e.grad_i_x = sat_out(gx);
         e.grad_i_y = sat_out(gy);
         e.grad_j_x = sat_out(-gx);
         e.grad_j_y = sat_out(-gy);
         return e;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(spring_force(r));
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report("result with no request outstanding");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.too_close) close_count++;
         compare_field("accel_x", got.accel_x, want.accel_x);
         compare_field("accel_y", got.accel_y, want.accel_y);
         compare_field("grad_i_x", got.grad_i_x, want.grad_i_x);
         compare_field("grad_i_y", got.grad_i_y, want.grad_i_y);
         compare_field("grad_j_x", got.grad_j_x, want.grad_j_x);
         compare_field("grad_j_y", got.grad_j_y, want.grad_j_y);
         compare_field("too_close", 32'(got.too_close), 32'(want.too_close));
      endtask
   endclass

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   spring_scoreboard sb = new();
   int send_idle_pct;
   int stall_pct;
   int hold_off_cycles;
   int quiet_cycles;
   int sent_count;

   always #5 clock = ~clock;

   spring_pair_force_jacobian_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Receiver: a requested hold-off stretch wins over random stalls.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor both channels on the edge, and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
            sent_count++;
         end
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   // Offer one request; return on the edge where it was accepted.
   task send_req(input req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every outstanding result is back.
   task drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leave the write enable high; the caller drops it after the last write.
   task write_reg(input csr_index_type idx, input logic [CFG_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   function automatic req_type make_pair(int ix, int iy, int jx, int jy, int vx, int vy);
      req_type t;
      t.pos_i_x = ix; t.pos_i_y = iy;
      t.pos_j_x = jx; t.pos_j_y = jy;
      t.adj_vel_x = vx; t.adj_vel_y = vy;
      return t;
   endfunction

   // Mostly pairs near each other so the spring math is exercised; some
   // fully random words to toggle every bit and hit saturation.
   function automatic req_type random_pair();
      req_type t;
      int      span;
      t.pos_i_x = $urandom;
      t.pos_i_y = $urandom;
      t.adj_vel_x = $urandom;
      t.adj_vel_y = $urandom;
      case ($urandom_range(3))
         0: begin
            t.pos_j_x = $urandom;
            t.pos_j_y = $urandom;
         end
         1, 2: begin
            span = ($urandom_range(1)) ? (1 << 18) : (int'(sb.min_q) * 2 + 16);
            if (span <= 0) span = 1 << 30;
            t.pos_i_x = $signed($urandom_range(1 << 24)) - (1 << 23);
            t.pos_i_y = $signed($urandom_range(1 << 24)) - (1 << 23);
            t.pos_j_x = t.pos_i_x + $signed($urandom_range(span)) - span / 2;
            t.pos_j_y = t.pos_i_y + $signed($urandom_range(span)) - span / 2;
            if ($urandom_range(1)) begin
               t.adj_vel_x = $signed($urandom_range(1 << 20)) - (1 << 19);
               t.adj_vel_y = $signed($urandom_range(1 << 20)) - (1 << 19);
            end
         end
         default: begin
            t.pos_j_x = $signed($urandom_range(1 << 20)) - (1 << 19);
            t.pos_j_y = $signed($urandom_range(1 << 20)) - (1 << 19);
            t.pos_i_x = $signed($urandom_range(1 << 20)) - (1 << 19);
            t.pos_i_y = $signed($urandom_range(1 << 20)) - (1 << 19);
         end
      endcase
      return t;
   endfunction

   // Edge pairs for the current settings: coincident masses, just under and
   // exactly at the minimum distance, and the widest separations.
   task send_edge_pairs();
      int m;
      m = int'(sb.min_q);
      send_req(make_pair(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      send_req(make_pair(0, 0, (m > 0) ? m - 1 : 1, 0, 1 << 16, -(1 << 16)));
      send_req(make_pair(0, 0, 0, m, 32'h8000_0000, 32'h7FFF_FFFF));
      send_req(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_req(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000));
   endtask

   initial begin
      int idle_set[4][2];
      idle_set = '{'{0, 0}, '{71, 0}, '{0, 71}, '{32, 32}};
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 0;
      quiet_cycles = 0;
      sent_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 5; ph++) begin
         // reprogram only with the pipeline empty
         if (ph > 0) begin
            drain();
            case (ph)
               1: begin
                  write_reg(CSR_MASS, 31'd1);
                  write_reg(CSR_STIFFNESS, 31'h7FFF_FFFF);
                  write_reg(CSR_REST_LENGTH, 31'd0);
                  write_reg(CSR_MIN_DISTANCE, 31'd0);
               end
               2: begin
                  write_reg(CSR_MASS, 31'h7FFF_FFFF);
                  write_reg(CSR_STIFFNESS, 31'h7FFF_FFFF);
                  write_reg(CSR_REST_LENGTH, 31'h7FFF_FFFF);
                  write_reg(CSR_MIN_DISTANCE, 31'h7FFF_FFFF);
               end
               3: begin
                  write_reg(CSR_MASS, 31'd0);
                  write_reg(CSR_STIFFNESS, 31'd0);
                  write_reg(CSR_REST_LENGTH, 31'd196608);
                  write_reg(CSR_MIN_DISTANCE, 31'd32768);
               end
               default: begin
                  write_reg(CSR_MASS, 31'($urandom_range(1 << 20, 1)));
                  write_reg(CSR_STIFFNESS, 31'($urandom_range(1 << 20)));
                  write_reg(CSR_REST_LENGTH, 31'($urandom_range(1 << 19)));
                  write_reg(CSR_MIN_DISTANCE, 31'($urandom_range(1 << 16)));
               end
            endcase
            csr_we <= 1'b0;
         end
         send_idle_pct = idle_set[ph % 4][0];
         stall_pct     = idle_set[ph % 4][1];
         send_edge_pairs();
         for (int n = 0; n < 165; n++) begin
            // long receiver hold while requests keep coming: fill the pipe
            if (ph == 1 && n == 20) hold_off_cycles = 600;
            // sender pause until the pipe runs dry
            if (ph == 2 && n == 80) drain();
            send_req(random_pair());
         end
      end

      drain();
      $display("Covered %0d requests, %0d results checked (%0d too close), 5 settings",
               sent_count, sb.checked, sb.close_count);
      $display("Idle mixes: none, sender, receiver, both; plus long hold-off and a full drain");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/spfj_pkg.sv
rtl/core/spfj_delay.sv
rtl/core/spfj_isqrt.sv
rtl/core/spfj_div.sv
rtl/core/spfj_mul.sv
rtl/core/spring_pair_force_jacobian_unit.sv
verif/tb.sv
